@@ src/kcsm_pkg.sv @@
// Package for the key chord sequence matcher.
// Holds the key and result types, request kind codes and the controller state type.
// No dependencies.
package kcsm_pkg;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_HDR   = 2'd2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } kcsm_state_t;

    typedef struct packed {
        logic [7:0]  mods;
        logic [31:0] sym;
    } kcsm_key_t;

    typedef struct packed {
        logic      en;
        logic [3:0] slot;
        logic [2:0] pos;
        kcsm_key_t  key;
    } kcsm_key_wr_t;

    typedef struct packed {
        logic [3:0] binding;
        logic [7:0] action;
        logic       fired;
        logic       consumed;
    } kcsm_result_t;

endpackage

@@ src/key_chord_sequence_matcher.sv @@
// Top level of the key chord sequence matcher: request control, binding scan and history.
// Depends on kcsm_pkg and kcsm_key_store.
//
// Channel | Dir | Contents
// s_      | in  | tuser: kind; tdata: index, position, symbol, modifiers, active, length, action
// m_      | out | tdata: consumed, fired, fired action, fired binding
//
// A load request moves the controller from idle to the done state, from which its result
// is loaded into the output register before the input opens again in idle.
// A key event scans one binding per cycle out of the header and key memories and stops at
// the first match; from the done state its result is loaded into the output register, and
// the input opens again once the controller is back in idle.
// One request is in flight at a time; a full output register stalls the controller.
// Reset marks all headers inactive and empties the history; the memories are not cleared.
module key_chord_sequence_matcher
    import kcsm_pkg::*;
#(
    parameter int NUM_BINDINGS   = 16,
    parameter int MAX_CHORD_KEYS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [3:0] binding_index, [6:4] key_position, [38:7] key_symbol, [46:39] key_modifiers,
    // [47] binding_active, [51:48] binding_length, [59:52] binding_action, [63:60] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] consumed, [1] fired, [9:2] fired_action, [13:10] fired_binding, [15:14] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int BW = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1;
    localparam int LW = $clog2(MAX_CHORD_KEYS + 1);
    localparam int HW = LW + 9;

    // Input fields.
    logic [3:0] in_slot;
    logic [2:0] in_pos;
    kcsm_key_t  in_key;
    logic       in_active;
    logic [3:0] in_len;
    logic [7:0] in_action;
    logic       s_accept;

    assign in_slot       = s_tdata[3:0];
    assign in_pos        = s_tdata[6:4];
    assign in_key.sym    = s_tdata[38:7];
    assign in_key.mods   = s_tdata[46:39];
    assign in_active     = s_tdata[47];
    assign in_len        = s_tdata[51:48];
    assign in_action     = s_tdata[59:52];
    assign s_accept      = s_tvalid && s_tready;

    kcsm_state_t state_reg, state_next;

    logic [BW-1:0] iss_reg, iss_next;
    logic [BW-1:0] eval_idx_reg, eval_idx_next;
    logic [BW-1:0] rd_addr;
    logic          out_load;

    kcsm_key_t                     ev_key_reg;
    kcsm_key_t [MAX_CHORD_KEYS-1:0] hist_reg;
    logic [LW-1:0]                 hist_count_reg, hist_count_next;
    kcsm_result_t                  res_reg, res_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]          m_tdata_reg;

    // Load write decode.
    logic [31:0]   slot_ext;
    logic [BW-1:0] wr_addr;
    logic          slot_ok;
    logic          key_wr_en;
    logic          hdr_wr_en;
    logic [LW-1:0] len_sat;
    kcsm_key_wr_t  key_wr;

    assign slot_ext  = 32'(in_slot);
    assign wr_addr   = slot_ext[BW-1:0];
    assign slot_ok   = slot_ext < 32'(NUM_BINDINGS);
    assign key_wr_en = s_accept && s_tuser == KIND_KEY && slot_ok
                       && 32'(in_pos) < 32'(MAX_CHORD_KEYS);
    assign hdr_wr_en = s_accept && s_tuser == KIND_HDR && slot_ok;
    assign len_sat   = (32'(in_len) > 32'(MAX_CHORD_KEYS)) ? LW'(MAX_CHORD_KEYS) : LW'(in_len);

    assign key_wr.en   = key_wr_en;
    assign key_wr.slot = in_slot;
    assign key_wr.pos  = in_pos;
    assign key_wr.key  = in_key;

    // Header memory with per-entry valid bits.
    logic [HW-1:0]           hdr_mem [NUM_BINDINGS];
    logic [HW-1:0]           hdr_rd_reg;
    logic [NUM_BINDINGS-1:0] hdr_valid_reg;
    logic                    hdr_vld_rd_reg;

    always_ff @(posedge aclk) begin
        if (hdr_wr_en) begin
            hdr_mem[wr_addr] <= {in_active, len_sat, in_action};
        end
        hdr_rd_reg <= hdr_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_valid_reg  <= '0;
            hdr_vld_rd_reg <= 1'b0;
        end else begin
            if (hdr_wr_en) begin
                hdr_valid_reg[wr_addr] <= 1'b1;
            end
            hdr_vld_rd_reg <= hdr_valid_reg[rd_addr];
        end
    end

    kcsm_key_t [MAX_CHORD_KEYS-1:0] rd_keys;

    kcsm_key_store #(
        .NUM_BINDINGS   (NUM_BINDINGS),
        .MAX_CHORD_KEYS (MAX_CHORD_KEYS),
        .BW             (BW)
    ) u_key_store (
        .aclk    (aclk),
        .wr      (key_wr),
        .rd_addr (rd_addr),
        .rd_keys (rd_keys)
    );

    // Match evaluation for the binding whose data arrived this cycle.
    logic          hdr_active;
    logic [LW-1:0] hdr_len;
    logic [7:0]    hdr_action;
    logic          prefix_ok;
    kcsm_key_t     next_key;
    logic          hit;
    logic          complete;
    logic          last_binding;
    logic          scan_end;
    logic [31:0]   eval_idx_ext;

    assign hdr_active   = hdr_rd_reg[HW-1];
    assign hdr_len      = hdr_rd_reg[HW-2:8];
    assign hdr_action   = hdr_rd_reg[7:0];
    assign eval_idx_ext = 32'(eval_idx_reg);

    always_comb begin
        prefix_ok = 1'b1;
        next_key  = '0;
        for (int l = 0; l < MAX_CHORD_KEYS; l++) begin
            if (32'(l) < 32'(hist_count_reg) && rd_keys[l] != hist_reg[l]) begin
                prefix_ok = 1'b0;
            end
            if (32'(l) == 32'(hist_count_reg)) begin
                next_key = rd_keys[l];
            end
        end
    end

    assign hit          = hdr_vld_rd_reg && hdr_active && hdr_len > hist_count_reg
                          && prefix_ok && next_key == ev_key_reg;
    assign complete     = ({1'b0, hist_count_reg} + (LW + 1)'(1)) == {1'b0, hdr_len};
    assign last_binding = eval_idx_reg == BW'(NUM_BINDINGS - 1);
    assign scan_end     = state_reg == ST_SCAN && (hit || last_binding);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == KIND_EVENT) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_tready      = 1'b0;
        out_load      = 1'b0;
        rd_addr       = '0;
        iss_next      = iss_reg;
        eval_idx_next = eval_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                iss_next      = (NUM_BINDINGS > 1) ? BW'(1) : '0;
                eval_idx_next = '0;
            end
            ST_SCAN: begin
                rd_addr       = iss_reg;
                iss_next      = (iss_reg == BW'(NUM_BINDINGS - 1)) ? iss_reg : iss_reg + BW'(1);
                eval_idx_next = last_binding ? eval_idx_reg : eval_idx_reg + BW'(1);
            end
            ST_DONE: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // History and result update.
    always_comb begin
        hist_count_next = hist_count_reg;
        res_next        = res_reg;
        if (s_accept) begin
            res_next = '0;
        end
        if (scan_end) begin
            res_next          = '0;
            res_next.consumed = hit || hist_count_reg != '0;
            if (hit && complete) begin
                res_next.fired   = 1'b1;
                res_next.action  = hdr_action;
                res_next.binding = eval_idx_ext[3:0];
                hist_count_next  = '0;
            end else if (hit) begin
                hist_count_next = hist_count_reg + LW'(1);
            end else begin
                hist_count_next = '0;
            end
        end
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            iss_reg        <= '0;
            eval_idx_reg   <= '0;
            hist_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            eval_idx_reg   <= eval_idx_next;
            hist_count_reg <= hist_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (s_accept) begin
            ev_key_reg <= in_key;
        end
        if (scan_end && hit && !complete) begin
            for (int l = 0; l < MAX_CHORD_KEYS; l++) begin
                if (32'(l) == 32'(hist_count_reg)) begin
                    hist_reg[l] <= ev_key_reg;
                end
            end
        end
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'(res_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_hist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(hist_count_reg) < 32'(MAX_CHORD_KEYS))
        else $error("history count reached the chord limit");

    a_fire_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_end && hit && complete) |=> hist_count_reg == '0)
        else $error("completed chord left history behind");

    a_load_keeps_hist: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser != KIND_EVENT) |=> $stable(hist_count_reg))
        else $error("load request changed the history");

    a_fired_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_reg.fired) |-> res_reg.consumed)
        else $error("fired result not marked consumed");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> 32'(eval_idx_reg) < 32'(NUM_BINDINGS))
        else $error("scan index past the binding table");

endmodule

@@ src/kcsm_key_store.sv @@
// Binding key storage: one synchronous memory per chord position, all read at one slot.
// Depends on kcsm_pkg.
module kcsm_key_store
    import kcsm_pkg::*;
#(
    parameter int NUM_BINDINGS   = 16,
    parameter int MAX_CHORD_KEYS = 8,
    parameter int BW             = 4
) (
    input  logic                               aclk,
    input  kcsm_key_wr_t                       wr,
    input  logic [BW-1:0]                      rd_addr,
    output kcsm_key_t [MAX_CHORD_KEYS-1:0]     rd_keys
);

    logic [31:0]   slot_ext;
    logic [31:0]   pos_ext;
    logic [BW-1:0] wr_addr;

    assign slot_ext = 32'(wr.slot);
    assign pos_ext  = 32'(wr.pos);
    assign wr_addr  = slot_ext[BW-1:0];

    for (genvar l = 0; l < MAX_CHORD_KEYS; l++) begin : g_lane
        kcsm_key_t lane_mem [NUM_BINDINGS];
        kcsm_key_t rd_reg;

        always_ff @(posedge aclk) begin
            if (wr.en && pos_ext == 32'(l)) begin
                lane_mem[wr_addr] <= wr.key;
            end
            rd_reg <= lane_mem[rd_addr];
        end

        assign rd_keys[l] = rd_reg;
    end

endmodule

@@ sim/key_chord_sequence_matcher_tb.sv @@
// Testbench for key_chord_sequence_matcher: directed and random requests on the stream ports.
// Every result is checked against an in-bench chord table and history predictor.
// Depends on kcsm_pkg and the key_chord_sequence_matcher RTL.
module key_chord_sequence_matcher_tb;
    import kcsm_pkg::*;

    localparam int NB = 16;
    localparam int MAXK = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  idx;
        logic [2:0]  pos;
        logic [31:0] sym;
        logic [7:0]  mods;
        logic        act;
        logic [3:0]  len;
        logic [7:0]  action;
    } chord_req_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    kcsm_key_t  chord_keys [NB][MAXK];
    bit         key_written [NB][MAXK];
    logic       hdr_active [NB];
    int         hdr_len [NB];
    logic [7:0] hdr_action [NB];
    kcsm_key_t  hist_keys [MAXK];
    int         hist_count;
    kcsm_key_t  key_pool [6];

    kcsm_result_t pending_results [$];

    bit src_idle_en;
    bit sink_stall_en;
    int stall_left;
    int errors;
    int cycle_count;
    int n_sent;
    int n_events;
    int n_consumed;
    int n_fired;
    int n_reprograms;

    key_chord_sequence_matcher #(
        .NUM_BINDINGS(NB),
        .MAX_CHORD_KEYS(MAXK)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("key_chord_sequence_matcher verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (sink_stall_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic bit prefix_agrees(input int b, input int n);
        for (int i = 0; i < n; i++) begin
            if (chord_keys[b][i] !== hist_keys[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic kcsm_result_t apply_request(input chord_req_t r);
        kcsm_result_t res;
        kcsm_key_t    k;
        int           progress;
        bit           hit;
        res = '0;
        k.sym = r.sym;
        k.mods = r.mods;
        case (r.kind)
            KIND_KEY: begin
                chord_keys[r.idx][r.pos] = k;
                key_written[r.idx][r.pos] = 1'b1;
            end
            KIND_HDR: begin
                hdr_active[r.idx] = r.act;
                hdr_len[r.idx] = (int'(r.len) > MAXK) ? MAXK : int'(r.len);
                hdr_action[r.idx] = r.action;
            end
            KIND_EVENT: begin
                progress = hist_count;
                hit = 1'b0;
                for (int b = 0; b < NB && !hit; b++) begin
                    if (!hdr_active[b] || hdr_len[b] <= progress) continue;
                    if (!prefix_agrees(b, progress)) continue;
                    if (chord_keys[b][progress] !== k) continue;
                    hit = 1'b1;
                    res.consumed = 1'b1;
                    if (hdr_len[b] == progress + 1) begin
                        res.fired = 1'b1;
                        res.action = hdr_action[b];
                        res.binding = b[3:0];
                        hist_count = 0;
                    end else begin
                        hist_keys[progress] = k;
                        hist_count = progress + 1;
                    end
                end
                if (!hit && hist_count != 0) begin
                    hist_count = 0;
                    res.consumed = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        kcsm_result_t want;
        kcsm_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[13:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %0h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("consumed", 32'(want.consumed), 32'(got.consumed));
                check_field("fired", 32'(want.fired), 32'(got.fired));
                check_field("fired_action", 32'(want.action), 32'(got.action));
                check_field("fired_binding", 32'(want.binding), 32'(got.binding));
            end
        end
    end

    task automatic send_request(input chord_req_t r);
        int gap;
        kcsm_result_t res;
        gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= r.kind;
        s_tdata <= {4'b0, r.action, r.len, r.act, r.mods, r.sym, r.pos, r.idx};
        do @(posedge aclk); while (!s_tready);
        res = apply_request(r);
        pending_results.push_back(res);
        n_sent++;
        if (r.kind == KIND_EVENT) n_events++;
        if (res.consumed) n_consumed++;
        if (res.fired) n_fired++;
    endtask

    task automatic wait_all_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic chord_req_t random_req();
        chord_req_t r;
        r.kind = KIND_EVENT;
        r.idx = 4'($urandom);
        r.pos = 3'($urandom);
        r.sym = $urandom;
        r.mods = 8'($urandom);
        r.act = 1'($urandom);
        r.len = 4'($urandom);
        r.action = 8'($urandom);
        return r;
    endfunction

    function automatic kcsm_key_t pick_key();
        kcsm_key_t k;
        if ($urandom_range(0, 99) < 85) begin
            k = key_pool[$urandom_range(0, 5)];
        end else begin
            k.sym = $urandom;
            k.mods = 8'($urandom);
        end
        return k;
    endfunction

    function automatic logic [3:0] random_len(input int max_len);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 4'd0;
        if (r == 1) return 4'($urandom_range(MAXK + 1, 15));
        return 4'($urandom_range(1, max_len));
    endfunction

    task automatic send_event(input kcsm_key_t k);
        chord_req_t r;
        r = random_req();
        r.sym = k.sym;
        r.mods = k.mods;
        send_request(r);
    endtask

    task automatic send_key_write(input logic [3:0] idx, input logic [2:0] pos,
                                  input kcsm_key_t k);
        chord_req_t r;
        r = random_req();
        r.kind = KIND_KEY;
        r.idx = idx;
        r.pos = pos;
        r.sym = k.sym;
        r.mods = k.mods;
        send_request(r);
    endtask

    task automatic send_header(input logic [3:0] idx, input logic act, input logic [3:0] len,
                               input logic [7:0] action);
        chord_req_t r;
        r = random_req();
        r.kind = KIND_HDR;
        r.idx = idx;
        r.act = act;
        r.len = len;
        r.action = action;
        send_request(r);
    endtask

    // An active binding only ever compares keys that have been written.
    task automatic load_header(input logic [3:0] idx, input logic act, input logic [3:0] len,
                               input logic [7:0] action, input bit fresh);
        int used;
        used = (int'(len) > MAXK) ? MAXK : int'(len);
        for (int p = 0; p < used; p++) begin
            if (act && (fresh || !key_written[idx][p])) send_key_write(idx, p[2:0], pick_key());
        end
        send_header(idx, act, len, action);
    endtask

    function automatic int pick_continuation();
        int cands [$];
        for (int b = 0; b < NB; b++) begin
            if (hdr_active[b] && hdr_len[b] > hist_count && prefix_agrees(b, hist_count))
                cands.push_back(b);
        end
        if (cands.size() == 0) return -1;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    function automatic kcsm_key_t long_chord_key(input int p);
        kcsm_key_t k;
        k.sym = 32'hA5A5_0000 | p;
        k.mods = 8'h01 << p;
        return k;
    endfunction

    task automatic test_unused_kind();
        chord_req_t r;
        r.kind = KIND_UNUSED;
        r.idx = '1;
        r.pos = '1;
        r.sym = '1;
        r.mods = '1;
        r.act = 1'b1;
        r.len = '1;
        r.action = '1;
        send_request(r);
    endtask

    task automatic test_zero_length_binding();
        send_header(4'd2, 1'b1, 4'd0, 8'h33);
    endtask

    task automatic test_single_key_chord();
        kcsm_key_t k;
        k = '1;
        send_key_write(4'd15, 3'd0, k);
        send_header(4'd15, 1'b1, 4'd1, 8'hFF);
        send_event(k);
    endtask

    task automatic test_inactive_binding();
        send_header(4'd15, 1'b0, 4'd1, 8'hFF);
        send_event('1);
    endtask

    task automatic test_long_chord();
        for (int p = 0; p < MAXK; p++) send_key_write(4'd1, p[2:0], long_chord_key(p));
        send_header(4'd1, 1'b1, 4'hF, 8'h5A);
        send_event(long_chord_key(0));
        send_event(long_chord_key(1));
        send_event(long_chord_key(0));
        for (int p = 0; p < MAXK; p++) send_event(long_chord_key(p));
    endtask

    task automatic test_random_traffic(input int max_len, input int count);
        int sel;
        int cand;
        chord_req_t r;
        wait_all_results();
        for (int b = 0; b < NB; b++) begin
            load_header(b[3:0], $urandom_range(0, 5) != 0, random_len(max_len),
                        8'($urandom), 1'b1);
        end
        n_reprograms++;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 68) begin
                cand = pick_continuation();
                if (cand >= 0) send_event(chord_keys[cand][hist_count]);
                else send_event(pick_key());
            end else if (sel < 82) begin
                send_event(pick_key());
            end else if (sel < 90) begin
                send_key_write(4'($urandom), 3'($urandom), pick_key());
            end else if (sel < 96) begin
                load_header(4'($urandom), $urandom_range(0, 5) != 0, random_len(max_len),
                            8'($urandom), 1'b0);
            end else begin
                r = random_req();
                r.kind = KIND_UNUSED;
                send_request(r);
            end
            if ($urandom_range(0, 149) == 0) wait_all_results();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_EVENT;
        src_idle_en = 1'b0;
        sink_stall_en = 1'b0;
        hist_count = 0;
        for (int b = 0; b < NB; b++) begin
            hdr_active[b] = 1'b0;
            hdr_len[b] = 0;
            hdr_action[b] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 6; i++) begin
            key_pool[i].sym = $urandom;
            key_pool[i].mods = 8'($urandom);
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_unused_kind();
        test_zero_length_binding();
        test_single_key_chord();
        test_inactive_binding();
        test_long_chord();

        src_idle_en = 1'b1;
        sink_stall_en = 1'b1;
        test_random_traffic(4, 420);
        test_random_traffic(MAXK, 330);
        src_idle_en = 1'b0;
        sink_stall_en = 1'b0;
        test_random_traffic(3, 210);

        wait_all_results();
        repeat (NB + 8) @(posedge aclk);
        $display("Sent %0d requests (%0d key events) over %0d table loads.",
                 n_sent, n_events, n_reprograms);
        $display("Key events consumed: %0d, chords completed: %0d.", n_consumed, n_fired);
        if (errors == 0) begin
            $display("key_chord_sequence_matcher verification clean");
        end else begin
            $display("key_chord_sequence_matcher verification failed");
        end
        $finish;
    end

endmodule
